// File: sv/ttlb_pkg.sv
`default_nettype none
package ttlb_pkg;

  localparam int SETS_DEF   = 64;
  localparam int PAGE_SHIFT = 12;
  localparam int VA_W       = 32;
  localparam int TAG_W      = VA_W - PAGE_SHIFT;
  localparam int OFF_W      = PAGE_SHIFT;
  localparam int SEG_W      = 24;
  localparam int PTE_W      = 32;

  // lower pte word bits
  localparam int PTE_C_BIT  = 7;
  localparam int PTE_W_BIT  = 6;
  localparam int PTE_I_BIT  = 5;

  localparam int IN_TDATA_W  = VA_W + SEG_W + PTE_W;
  localparam int IN_TUSER_W  = 5;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 2;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_FILL   = 2'd1,
    ACT_INVAL  = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    KIND_READ   = 3'd0,
    KIND_WRITE  = 3'd1,
    KIND_FETCH  = 3'd2,
    KIND_DPROBE = 3'd3,
    KIND_IPROBE = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    OUT_HIT      = 2'd0,
    OUT_UPDATE_C = 2'd1,
    OUT_MISS     = 2'd2,
    OUT_DONE     = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [SEG_W-1:0] seg;
    logic [PTE_W-1:0] pte;
  } way_t;

  typedef struct packed {
    logic       recent;
    way_t [1:0] way;
  } tlb_t;

  // one memory row holds a set of both buffers: tlb[0] data, tlb[1] instruction
  typedef struct packed {
    tlb_t [1:0] tlb;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    action_t          action;
    kind_t            kind;
    logic [TAG_W-1:0] tag;
    logic [OFF_W-1:0] off;
    logic [SEG_W-1:0] seg;
    logic [PTE_W-1:0] pte;
  } op_t;

  typedef struct packed {
    outcome_t        outcome;
    logic [VA_W-1:0] pa;
    logic            wti;
  } result_t;

endpackage
`default_nettype wire

// File: sv/ttlb_ram.sv
`default_nettype none
module ttlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// File: sv/ttlb_upd.sv
`default_nettype none
module ttlb_upd (
  input  wire ttlb_pkg::op_t     op_i,
  input  wire ttlb_pkg::row_t    row_i,
  output ttlb_pkg::row_t         row_o,
  output ttlb_pkg::result_t      res_o
);

  logic                       bsel;
  logic                       probe;
  logic                       hit0;
  logic                       hit1;
  logic                       hway;
  logic                       victim;
  logic [ttlb_pkg::PTE_W-1:0] hit_pte;

  assign bsel  = (op_i.kind == ttlb_pkg::KIND_FETCH) || (op_i.kind == ttlb_pkg::KIND_IPROBE);
  assign probe = (op_i.kind == ttlb_pkg::KIND_DPROBE) || (op_i.kind == ttlb_pkg::KIND_IPROBE);

  assign hit0 = row_i.tlb[bsel].way[0].valid && (row_i.tlb[bsel].way[0].tag == op_i.tag) &&
                (row_i.tlb[bsel].way[0].seg == op_i.seg);
  assign hit1 = row_i.tlb[bsel].way[1].valid && (row_i.tlb[bsel].way[1].tag == op_i.tag) &&
                (row_i.tlb[bsel].way[1].seg == op_i.seg);
  // way 0 wins when both match
  assign hway    = !hit0;
  assign hit_pte = row_i.tlb[bsel].way[hway].pte;

  // way 1 only when way 0 is valid and the recent bit points at way 0
  assign victim = !row_i.tlb[bsel].recent && row_i.tlb[bsel].way[0].valid;

  always_comb begin
    row_o         = row_i;
    res_o.outcome = ttlb_pkg::OUT_DONE;
    res_o.pa      = '0;
    res_o.wti     = 1'b0;
    unique case (op_i.action)
      ttlb_pkg::ACT_LOOKUP: begin
        res_o.outcome = ttlb_pkg::OUT_MISS;
        if (hit0 || hit1) begin
          if ((op_i.kind == ttlb_pkg::KIND_WRITE) && !hit_pte[ttlb_pkg::PTE_C_BIT]) begin
            row_o.tlb[bsel].way[hway].pte[ttlb_pkg::PTE_C_BIT] = 1'b1;
            res_o.outcome = ttlb_pkg::OUT_UPDATE_C;
          end else begin
            if (!probe) begin
              row_o.tlb[bsel].recent = hway;
            end
            res_o.outcome = ttlb_pkg::OUT_HIT;
            res_o.pa      = {hit_pte[ttlb_pkg::PTE_W-1:ttlb_pkg::PAGE_SHIFT], op_i.off};
            res_o.wti     = hit_pte[ttlb_pkg::PTE_W_BIT] | hit_pte[ttlb_pkg::PTE_I_BIT];
          end
        end
      end
      ttlb_pkg::ACT_FILL: begin
        if (!probe) begin
          row_o.tlb[bsel].recent            = victim;
          row_o.tlb[bsel].way[victim].valid = 1'b1;
          row_o.tlb[bsel].way[victim].tag   = op_i.tag;
          row_o.tlb[bsel].way[victim].seg   = op_i.seg;
          row_o.tlb[bsel].way[victim].pte   = op_i.pte;
        end
      end
      ttlb_pkg::ACT_INVAL: begin
        for (int b = 0; b < 2; b++) begin
          row_o.tlb[b].recent       = 1'b0;
          row_o.tlb[b].way[0].valid = 1'b0;
          row_o.tlb[b].way[1].valid = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// File: sv/two_way_tlb_lookup_fill_top.sv
// Instruction and data TLBs, two-way set-associative with a recent-way bit per set.
// Each item is a lookup, a fill, a set invalidate or a no-op and yields exactly one
// result item. Both buffers share one memory row per set, so every item is one read
// and one write-back of that row (accept, row read, write-back); the write-back waits
// while the output register holds a result not yet taken. The next item is accepted
// as soon as the write-back is done, even while the result still waits there. After
// reset a clearing pass writes every row before the first item is accepted. The set
// index is the page tag modulo SETS; SETS need not be a power of two.
`default_nettype none
module two_way_tlb_lookup_fill_top #(
  parameter int SETS = ttlb_pkg::SETS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // virtual_page_address, segment_id, pte_word
  input  wire logic [ttlb_pkg::IN_TDATA_W-1:0]  in_tdata,
  // action, access_kind
  input  wire logic [ttlb_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // physical_address, write_through_or_inhibit, zero fill
  output logic      [ttlb_pkg::OUT_TDATA_W-1:0] out_tdata,
  // outcome
  output logic      [ttlb_pkg::OUT_TUSER_W-1:0] out_tuser
);

  localparam int TW = ttlb_pkg::TAG_W;
  localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
  // tag / SETS as a multiply by a rounded-up reciprocal, exact for all tags
  localparam int K  = TW + SW;
  localparam longint unsigned RECIP = ((longint'(1) << K) + longint'(SETS) - 1) / longint'(SETS);
  localparam logic [TW:0] RECIP_M = RECIP[TW:0];
  localparam int PW = 2 * TW + 1;
  localparam int QW = PW - K;

  ttlb_pkg::state_t  state_r, state_nxt;
  logic [SW-1:0]     clr_cnt_r, clr_cnt_nxt;
  ttlb_pkg::op_t     op_r, op_in;
  logic [QW-1:0]     q_r;
  logic [SW-1:0]     set_r;
  logic [TW-1:0]     rem;
  logic [PW-1:0]     prod;
  logic              out_valid_r;
  ttlb_pkg::result_t out_res_r;
  ttlb_pkg::result_t res_upd;
  ttlb_pkg::row_t    row_rd;
  ttlb_pkg::row_t    row_upd;
  logic                       ram_wr_en;
  logic                       ram_rd_en;
  logic [SW-1:0]              ram_wr_addr;
  logic [ttlb_pkg::ROW_W-1:0] ram_wr_data;
  logic [ttlb_pkg::ROW_W-1:0] ram_rd_data;
  logic                       load_out;
  logic                       in_acc;

  assign op_in.action = ttlb_pkg::action_t'(in_tuser[1:0]);
  assign op_in.kind   = ttlb_pkg::kind_t'(in_tuser[4:2]);
  assign op_in.tag    = in_tdata[ttlb_pkg::VA_W-1:ttlb_pkg::PAGE_SHIFT];
  assign op_in.off    = in_tdata[ttlb_pkg::PAGE_SHIFT-1:0];
  assign op_in.seg    = in_tdata[ttlb_pkg::VA_W +: ttlb_pkg::SEG_W];
  assign op_in.pte    = in_tdata[ttlb_pkg::VA_W + ttlb_pkg::SEG_W +: ttlb_pkg::PTE_W];

  assign in_acc = in_tvalid && in_tready;
  assign prod   = PW'(op_in.tag) * PW'(RECIP_M);
  assign rem    = op_r.tag - TW'(TW'(q_r) * TW'(SETS));

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    in_tready   = 1'b0;
    ram_wr_en   = 1'b0;
    ram_rd_en   = 1'b0;
    ram_wr_addr = set_r;
    ram_wr_data = row_upd;
    load_out    = 1'b0;
    unique case (state_r)
      ttlb_pkg::ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_cnt_r;
        ram_wr_data = '0;
        if (clr_cnt_r == SW'(SETS - 1)) begin
          state_nxt = ttlb_pkg::ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      ttlb_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ttlb_pkg::ST_READ;
        end
      end
      ttlb_pkg::ST_READ: begin
        ram_rd_en = 1'b1;
        state_nxt = ttlb_pkg::ST_WRITE;
      end
      ttlb_pkg::ST_WRITE: begin
        if (!out_valid_r || out_tready) begin
          ram_wr_en = 1'b1;
          load_out  = 1'b1;
          state_nxt = ttlb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ttlb_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ttlb_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r <= op_in;
      q_r  <= prod[PW-1:K];
    end
    if (state_r == ttlb_pkg::ST_READ) begin
      set_r <= rem[SW-1:0];
    end
    if (load_out) begin
      out_res_r <= res_upd;
    end
  end

  ttlb_ram #(
    .WIDTH (ttlb_pkg::ROW_W),
    .DEPTH (SETS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (rem[SW-1:0]),
    .rd_data (ram_rd_data)
  );

  assign row_rd = ram_rd_data;

  ttlb_upd u_upd (
    .op_i  (op_r),
    .row_i (row_rd),
    .row_o (row_upd),
    .res_o (res_upd)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.outcome;
  assign out_tdata  = {{(ttlb_pkg::OUT_TDATA_W - ttlb_pkg::VA_W - 1){1'b0}},
                       out_res_r.wti, out_res_r.pa};

  a_set_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ttlb_pkg::ST_READ) |-> (rem < TW'(SETS)))
    else $error("set index out of range");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_wr_en && ram_rd_en))
    else $error("row read and write in the same cycle");

  a_read_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (ram_rd_en && !in_tready))
    else $error("row read does not follow accepted item");

  a_zero_unless_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != ttlb_pkg::OUT_HIT)) |-> (out_tdata == '0))
    else $error("nonzero address on a non-hit result");

endmodule
`default_nettype wire

// File: tb/tlb_translate_checker.sv
`timescale 1ns / 1ps
module tlb_translate_checker
  import ttlb_pkg::*;
#(
  parameter int SETS = SETS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  input  wire logic                   in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,
  input  wire logic                   out_tvalid,
  input  wire logic                   out_tready,
  input  wire logic [OUT_TDATA_W-1:0] out_tdata,
  input  wire logic [OUT_TUSER_W-1:0] out_tuser,
  output int                          mismatches,
  output int                          outstanding
);

  // shadow copy of both buffers: [buffer][set][way], buffer 0 data, 1 instruction
  bit             shadow_valid [2][SETS][2];
  bit [TAG_W-1:0] shadow_tag   [2][SETS][2];
  bit [SEG_W-1:0] shadow_seg   [2][SETS][2];
  bit [PTE_W-1:0] shadow_pte   [2][SETS][2];
  bit             shadow_recent[2][SETS];

  result_t translations_q[$];
  int      reported;

  function automatic result_t translate_item(logic [1:0] act, logic [2:0] kind,
                                             logic [VA_W-1:0] vpa, logic [SEG_W-1:0] seg,
                                             logic [PTE_W-1:0] pte);
    result_t          res;
    logic [TAG_W-1:0] tag;
    int               set_idx;
    int               tlb_sel;
    int               w;
    bit               probe;
    bit               found;
    res.outcome = OUT_DONE;
    res.pa      = '0;
    res.wti     = 1'b0;
    tag     = vpa[VA_W-1:PAGE_SHIFT];
    set_idx = tag % SETS;
    tlb_sel = (kind == KIND_FETCH || kind == KIND_IPROBE) ? 1 : 0;
    probe   = (kind == KIND_DPROBE || kind == KIND_IPROBE);
    case (act)
      ACT_LOOKUP: begin
        res.outcome = OUT_MISS;
        found = 1'b0;
        for (w = 0; w < 2 && !found; w++) begin
          if (shadow_valid[tlb_sel][set_idx][w] && shadow_tag[tlb_sel][set_idx][w] == tag &&
              shadow_seg[tlb_sel][set_idx][w] == seg) begin
            found = 1'b1;
            if (kind == KIND_WRITE && !shadow_pte[tlb_sel][set_idx][w][PTE_C_BIT]) begin
              // first write to the page: only the change bit is recorded
              shadow_pte[tlb_sel][set_idx][w][PTE_C_BIT] = 1'b1;
              res.outcome = OUT_UPDATE_C;
            end else begin
              if (!probe) shadow_recent[tlb_sel][set_idx] = (w == 1);
              res.outcome = OUT_HIT;
              res.pa  = {shadow_pte[tlb_sel][set_idx][w][PTE_W-1:PAGE_SHIFT],
                         vpa[PAGE_SHIFT-1:0]};
              res.wti = shadow_pte[tlb_sel][set_idx][w][PTE_W_BIT] |
                        shadow_pte[tlb_sel][set_idx][w][PTE_I_BIT];
            end
          end
        end
      end
      ACT_FILL: begin
        if (!probe) begin
          // way 1 only when way 0 is valid and recent points at way 0
          w = (!shadow_recent[tlb_sel][set_idx] && shadow_valid[tlb_sel][set_idx][0]) ? 1 : 0;
          shadow_recent[tlb_sel][set_idx]   = (w == 1);
          shadow_valid[tlb_sel][set_idx][w] = 1'b1;
          shadow_tag[tlb_sel][set_idx][w]   = tag;
          shadow_seg[tlb_sel][set_idx][w]   = seg;
          shadow_pte[tlb_sel][set_idx][w]   = pte;
        end
      end
      ACT_INVAL: begin
        for (w = 0; w < 2; w++) begin
          shadow_valid[w][set_idx][0] = 1'b0;
          shadow_valid[w][set_idx][1] = 1'b0;
          shadow_recent[w][set_idx]   = 1'b0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  initial begin
    mismatches  = 0;
    outstanding = 0;
    reported    = 0;
  end

  always @(posedge clk) begin
    result_t want;
    int      pushed;
    int      popped;
    pushed = 0;
    popped = 0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        translations_q.push_back(translate_item(in_tuser[1:0], in_tuser[4:2],
                                                in_tdata[31:0], in_tdata[55:32],
                                                in_tdata[87:56]));
        pushed = 1;
      end
      if (out_tvalid && out_tready) begin
        if (translations_q.size() == 0) begin
          mismatches++;
          if (reported < 10) begin
            reported++;
            $display("%0t: result item with none expected: outcome %0d pa %h wti %b",
                     $realtime, out_tuser, out_tdata[31:0], out_tdata[32]);
          end
        end else begin
          want = translations_q.pop_front();
          popped = 1;
          if (out_tuser !== want.outcome || out_tdata[31:0] !== want.pa ||
              out_tdata[32] !== want.wti) begin
            mismatches++;
            if (reported < 10) begin
              reported++;
              $display("%0t: tlb result mismatch: expected outcome %0d pa %h wti %b, got outcome %0d pa %h wti %b",
                       $realtime, want.outcome, want.pa, want.wti,
                       out_tuser, out_tdata[31:0], out_tdata[32]);
            end
          end
        end
      end
    end
    outstanding <= outstanding + pushed - popped;
  end

endmodule

// File: tb/two_way_tlb_lookup_fill_top_test.sv
`timescale 1ns / 1ps
module two_way_tlb_lookup_fill_top_test;
  import ttlb_pkg::*;

  localparam int SETS         = SETS_DEF;
  localparam int RANDOM_ITEMS = 1000;
  localparam int CYCLE_LIMIT  = 400000;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  int                     mismatches;
  int                     outstanding;

  // small working set of pages so fills and lookups collide in a few sets
  logic [TAG_W-1:0] page_pool[8];
  logic [SEG_W-1:0] seg_pool[2];
  bit               no_gaps;

  two_way_tlb_lookup_fill_top #(.SETS(SETS)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  tlb_translate_checker #(.SETS(SETS)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [2:0] pick_kind();
    if ($urandom_range(0, 99) < 6) return 3'($urandom_range(5, 7));
    return 3'($urandom_range(KIND_READ, KIND_IPROBE));
  endfunction

  task automatic refresh_pools();
    int sets_used[4];
    int i;
    for (i = 0; i < 4; i++) sets_used[i] = $urandom_range(0, SETS - 1);
    for (i = 0; i < 8; i++)
      page_pool[i] = TAG_W'($urandom_range(0, (1 << TAG_W) / SETS - 1) * SETS + sets_used[i % 4]);
    for (i = 0; i < 2; i++) seg_pool[i] = SEG_W'($urandom);
  endtask

  task automatic send_item(logic [1:0] act, logic [2:0] kind, logic [VA_W-1:0] vpa,
                           logic [SEG_W-1:0] seg, logic [PTE_W-1:0] pte);
    int gap;
    gap = no_gaps ? 0 : gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {kind, act};
    in_tdata  <= {pte, seg, vpa};
    do @(posedge clk); while (!in_tready);
  endtask

  // result side back-pressure
  initial begin
    int len;
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      len = gap_len();
      if (len > 0) begin
        out_tready <= 1'b0;
        repeat (len) @(posedge clk);
      end
      out_tready <= 1'b1;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      repeat (len) @(posedge clk);
    end
  end

  initial begin
    int n;
    int r;
    logic [TAG_W-1:0] tag;
    logic [SEG_W-1:0] seg;
    logic [VA_W-1:0]  vpa;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    no_gaps   = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty buffers, then the all-ones page in the last set
    send_item(ACT_LOOKUP, KIND_READ,   32'h0000_0000, 24'h00_0000, 32'h0000_0000);
    send_item(ACT_FILL,   KIND_READ,   32'hFFFF_F000, 24'hFF_FFFF, 32'hFFFF_FFFF);
    send_item(ACT_LOOKUP, KIND_READ,   32'hFFFF_FFFF, 24'hFF_FFFF, 32'h0000_0000);
    // first write to a clean page, then the normal write hit
    send_item(ACT_FILL,   KIND_WRITE,  32'h0000_0000, 24'h00_0000, 32'h0000_0000);
    send_item(ACT_LOOKUP, KIND_WRITE,  32'h0000_0ABC, 24'h00_0000, 32'h0000_0000);
    send_item(ACT_LOOKUP, KIND_WRITE,  32'h0000_0ABC, 24'h00_0000, 32'h0000_0000);
    send_item(ACT_LOOKUP, KIND_DPROBE, 32'h0000_0000, 24'h00_0000, 32'h0000_0000);
    // instruction buffer is separate from the data buffer
    send_item(ACT_LOOKUP, KIND_FETCH,  32'h0000_0000, 24'h00_0000, 32'h0000_0000);
    send_item(ACT_FILL,   KIND_FETCH,  32'h1234_5000, 24'h5A_5A5A, 32'hCAFE_0048);
    send_item(ACT_LOOKUP, KIND_IPROBE, 32'h1234_5FFF, 24'h5A_5A5A, 32'h0000_0000);
    // probe fill leaves the buffer alone
    send_item(ACT_FILL,   KIND_DPROBE, 32'h0004_0000, 24'h00_0000, 32'h5555_50A8);
    send_item(ACT_LOOKUP, KIND_READ,   32'h0004_0000, 24'h00_0000, 32'h0000_0000);
    // victim choice in set 0: way 1 first, then way 0 replaces the changed page
    send_item(ACT_FILL,   KIND_READ,   32'h0004_0000, 24'h00_0001, 32'h1111_1020);
    send_item(ACT_FILL,   KIND_READ,   32'h0008_0000, 24'h00_0002, 32'h2222_2080);
    send_item(ACT_LOOKUP, KIND_READ,   32'h0000_0000, 24'h00_0000, 32'h0000_0000);
    send_item(ACT_LOOKUP, KIND_READ,   32'h0004_0123, 24'h00_0001, 32'h0000_0000);
    // unknown kind acts as a data read, the no-op action just answers done
    send_item(ACT_LOOKUP, 3'd7,        32'h0008_0456, 24'h00_0002, 32'h0000_0000);
    send_item(ACT_NOP,    KIND_READ,   32'h0004_0000, 24'h00_0001, 32'hFFFF_FFFF);
    send_item(ACT_INVAL,  KIND_IPROBE, 32'h0000_0000, 24'h00_0000, 32'h0000_0000);
    send_item(ACT_LOOKUP, KIND_READ,   32'h0004_0123, 24'h00_0001, 32'h0000_0000);
    send_item(ACT_LOOKUP, KIND_READ,   32'hFFFF_F000, 24'h7F_FFFF, 32'h0000_0000);
    send_item(ACT_INVAL,  KIND_READ,   32'hFFFF_F000, 24'h00_0000, 32'h0000_0000);
    send_item(ACT_LOOKUP, KIND_READ,   32'hFFFF_F000, 24'hFF_FFFF, 32'h0000_0000);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 250 == 0) refresh_pools();
      if (n % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      tag = page_pool[$urandom_range(0, 7)];
      seg = seg_pool[$urandom_range(0, 1)];
      vpa = {tag, 12'($urandom)};
      r   = $urandom_range(0, 99);
      if (r < 30)      send_item(ACT_FILL, pick_kind(), vpa, seg, $urandom);
      else if (r < 80) send_item(ACT_LOOKUP, pick_kind(), vpa, seg, $urandom);
      else if (r < 86) send_item(ACT_LOOKUP, pick_kind(), $urandom, SEG_W'($urandom), $urandom);
      else if (r < 92) send_item(ACT_LOOKUP, pick_kind(), vpa, SEG_W'($urandom), $urandom);
      else if (r < 97) send_item(ACT_INVAL, pick_kind(), vpa, seg, $urandom);
      else             send_item(ACT_NOP, pick_kind(), $urandom, SEG_W'($urandom), $urandom);
    end
    in_tvalid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

endmodule
